// ===== rtl/core/vmb_pkg.sv =====
// shared types, constants and fixed-point helpers for the view matrix builder
// no dependencies; used by every module under rtl/core
package vmb_pkg;

  localparam int VW = 52;
  localparam int UW = 19;
  localparam int ITEM_CYC = 4;
  localparam logic [1:0] LAST_ROW = 2'd3;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [VW-1:0] vec_el_t;
  typedef logic signed [UW-1:0] unit_t;

  typedef struct packed {
    q16_t [2:0] eye;
    q16_t [2:0] up;
    unit_t [2:0] v;
    logic ok;
  } side_t;

  typedef struct packed {
    logic vld;
    logic ok;
    q16_t [2:0][3:0] m;
  } mat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] round16(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + 64'd32768) >> 16;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== rtl/core/vmb_unitize.sv =====
// pipelined vector normalizer: scale, sum of squares, square root, divide
// depends on vmb_pkg
module vmb_unitize (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  vmb_pkg::vec_el_t [2:0] in_v,
  input  vmb_pkg::side_t in_side,
  output logic out_vld,
  output vmb_pkg::unit_t [2:0] out_u,
  output vmb_pkg::side_t out_side
);

  localparam int MW = vmb_pkg::VW;
  localparam int AW = 30;
  localparam int NW = 64;
  localparam int LW = 32;
  localparam int RW = 50;
  localparam int QW = 18;
  localparam int SQ_ST = 16;
  localparam int DV_ST = 9;
  localparam logic [5:0] TOPB = 6'(AW - 1);
  localparam logic [NW-1:0] BIT0 = 64'd1 << 62;

  typedef struct packed {
    logic vld;
    logic zero;
    logic [2:0] neg;
    logic [2:0][AW-1:0] al;
    logic [NW-1:0] n;
    logic [NW-1:0] r;
    vmb_pkg::side_t side;
  } sq_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic [2:0] neg;
    logic [2:0][RW-1:0] rem;
    logic [LW:0] d;
    logic [2:0][QW-1:0] q;
    vmb_pkg::side_t side;
  } dv_t;

  function automatic logic [5:0] msb_pos(input logic [MW-1:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) if (x[i]) p = 6'(i);
    return p;
  endfunction

  function automatic logic [2*NW-1:0] sq_step(input logic [NW-1:0] n,
                                             input logic [NW-1:0] r,
                                             input logic [NW-1:0] b);
    logic [NW-1:0] t;
    t = r + b;
    if (n >= t) return {n - t, (r >> 1) + b};
    return {n, r >> 1};
  endfunction

  logic s1_vld, s2_vld, s3_vld, s4_vld;
  logic [2:0][MW-1:0] s1_mag, s2_mag;
  logic [2:0] s1_neg, s2_neg, s3_neg, s4_neg;
  logic [MW-1:0] s1_m;
  logic [5:0] s2_p;
  logic s2_zero, s3_zero, s4_zero;
  logic [2:0][AW-1:0] s3_al, s4_al;
  logic [2:0][2*AW-1:0] s4_sqr;
  vmb_pkg::side_t s1_side, s2_side, s3_side, s4_side;

  logic [2:0][MW-1:0] mag_c;
  logic [MW-1:0] m_c;
  logic [2:0][AW-1:0] al_c;

  sq_t sq [0:SQ_ST];
  sq_t sq_nx [1:SQ_ST];
  dv_t dv [0:DV_ST];
  dv_t dv_nx [0:DV_ST];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_v[i][MW-1] ? MW'(-in_v[i]) : MW'(in_v[i]);
    end
    m_c = mag_c[0];
    if (mag_c[1] > m_c) m_c = mag_c[1];
    if (mag_c[2] > m_c) m_c = mag_c[2];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_p >= TOPB) al_c[i] = AW'(s2_mag[i] >> (s2_p - TOPB));
      else al_c[i] = AW'(s2_mag[i] << (TOPB - s2_p));
    end
  end

  always_comb begin
    for (int j = 1; j <= SQ_ST; j++) begin
      sq_nx[j] = sq[j-1];
      {sq_nx[j].n, sq_nx[j].r} = sq_step(sq[j-1].n, sq[j-1].r, BIT0 >> (4 * (j - 1)));
      {sq_nx[j].n, sq_nx[j].r} = sq_step(sq_nx[j].n, sq_nx[j].r,
                                         BIT0 >> (4 * (j - 1) + 2));
    end
  end

  always_comb begin
    int k;
    logic [RW-1:0] t;
    dv_nx[0].vld = sq[SQ_ST].vld;
    dv_nx[0].zero = sq[SQ_ST].zero;
    dv_nx[0].neg = sq[SQ_ST].neg;
    dv_nx[0].side = sq[SQ_ST].side;
    dv_nx[0].d = {sq[SQ_ST].r[LW-1:0], 1'b0};
    dv_nx[0].q = '0;
    for (int i = 0; i < 3; i++) begin
      dv_nx[0].rem[i] = (RW'(sq[SQ_ST].al[i]) << 17) + RW'(sq[SQ_ST].r[LW-1:0]);
    end
    for (int j = 1; j <= DV_ST; j++) begin
      dv_nx[j] = dv[j-1];
      for (int s = 0; s < 2; s++) begin
        k = QW - 1 - 2 * (j - 1) - s;
        t = RW'(dv[j-1].d) << k;
        for (int i = 0; i < 3; i++) begin
          if (dv_nx[j].rem[i] >= t) begin
            dv_nx[j].rem[i] = dv_nx[j].rem[i] - t;
            dv_nx[j].q[i][k] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      out_vld <= 1'b0;
      for (int j = 0; j <= SQ_ST; j++) sq[j].vld <= 1'b0;
      for (int j = 0; j <= DV_ST; j++) dv[j].vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
      s1_mag <= mag_c;
      s1_m <= m_c;
      s1_side <= in_side;
      for (int i = 0; i < 3; i++) s1_neg[i] <= in_v[i][MW-1];

      s2_vld <= s1_vld;
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
      s2_p <= msb_pos(s1_m);
      s2_zero <= (s1_m == '0);
      s2_side <= s1_side;

      s3_vld <= s2_vld;
      s3_al <= al_c;
      s3_neg <= s2_neg;
      s3_zero <= s2_zero;
      s3_side <= s2_side;

      s4_vld <= s3_vld;
      s4_al <= s3_al;
      s4_neg <= s3_neg;
      s4_zero <= s3_zero;
      s4_side <= s3_side;
      for (int i = 0; i < 3; i++) s4_sqr[i] <= s3_al[i] * s3_al[i];

      sq[0].vld <= s4_vld;
      sq[0].zero <= s4_zero;
      sq[0].neg <= s4_neg;
      sq[0].al <= s4_al;
      sq[0].side <= s4_side;
      sq[0].n <= NW'(s4_sqr[0]) + NW'(s4_sqr[1]) + NW'(s4_sqr[2]);
      sq[0].r <= '0;
      for (int j = 1; j <= SQ_ST; j++) sq[j] <= sq_nx[j];
      for (int j = 0; j <= DV_ST; j++) dv[j] <= dv_nx[j];

      out_vld <= dv[DV_ST].vld;
      out_side.eye <= dv[DV_ST].side.eye;
      out_side.up <= dv[DV_ST].side.up;
      out_side.v <= dv[DV_ST].side.v;
      out_side.ok <= dv[DV_ST].side.ok & ~dv[DV_ST].zero;
      for (int i = 0; i < 3; i++) begin
        if (dv[DV_ST].zero) out_u[i] <= '0;
        else if (dv[DV_ST].neg[i]) out_u[i] <= -$signed({1'b0, dv[DV_ST].q[i]});
        else out_u[i] <= $signed({1'b0, dv[DV_ST].q[i]});
      end
    end
  end

endmodule

// ===== rtl/core/vmb_cross.sv =====
// two-stage cross product of the forward direction with the up hint
// depends on vmb_pkg
module vmb_cross (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  vmb_pkg::side_t in_side,
  output logic out_vld,
  output vmb_pkg::vec_el_t [2:0] out_c,
  output vmb_pkg::side_t out_side
);

  logic p_vld;
  logic signed [50:0] p [0:5];
  vmb_pkg::side_t p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      p_vld <= in_vld;
      p_side <= in_side;
      p[0] <= $signed(in_side.v[1]) * $signed(in_side.up[2]);
      p[1] <= $signed(in_side.v[2]) * $signed(in_side.up[1]);
      p[2] <= $signed(in_side.v[2]) * $signed(in_side.up[0]);
      p[3] <= $signed(in_side.v[0]) * $signed(in_side.up[2]);
      p[4] <= $signed(in_side.v[0]) * $signed(in_side.up[1]);
      p[5] <= $signed(in_side.v[1]) * $signed(in_side.up[0]);

      out_vld <= p_vld;
      out_side <= p_side;
      out_c[0] <= vmb_pkg::VW'(p[0]) - vmb_pkg::VW'(p[1]);
      out_c[1] <= vmb_pkg::VW'(p[2]) - vmb_pkg::VW'(p[3]);
      out_c[2] <= vmb_pkg::VW'(p[4]) - vmb_pkg::VW'(p[5]);
    end
  end

endmodule

// ===== rtl/core/vmb_rows.sv =====
// true up vector, eye dot products, rounding and saturation of rows 0 to 2
// depends on vmb_pkg
module vmb_rows (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  vmb_pkg::unit_t [2:0] in_a,
  input  vmb_pkg::side_t in_side,
  output vmb_pkg::mat_t out_mat
);

  typedef struct packed {
    logic vld;
    logic ok;
    vmb_pkg::unit_t [2:0] a;
    vmb_pkg::unit_t [2:0] v;
    vmb_pkg::q16_t [2:0] eye;
  } cr_t;

  cr_t c1, c2, c3, c4;
  logic signed [37:0] pb [0:5];
  logic signed [50:0] pa [0:2];
  logic signed [50:0] pv [0:2];
  logic signed [38:0] braw [0:2];
  logic signed [52:0] da, dv;
  logic signed [23:0] b3 [0:2];
  logic signed [23:0] b4 [0:2];
  logic signed [31:0] ta3, tv3, ta4, tv4;
  logic signed [55:0] pbe [0:2];
  logic signed [31:0] tb;

  always_comb begin
    tb = vmb_pkg::sat32(-vmb_pkg::round16(64'(pbe[0]) + 64'(pbe[1]) + 64'(pbe[2])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
      c2.vld <= 1'b0;
      c3.vld <= 1'b0;
      c4.vld <= 1'b0;
      out_mat.vld <= 1'b0;
    end else begin
      c1 <= {in_vld, in_side.ok, in_a, in_side.v, in_side.eye};
      pb[0] <= $signed(in_a[1]) * $signed(in_side.v[2]);
      pb[1] <= $signed(in_a[2]) * $signed(in_side.v[1]);
      pb[2] <= $signed(in_a[2]) * $signed(in_side.v[0]);
      pb[3] <= $signed(in_a[0]) * $signed(in_side.v[2]);
      pb[4] <= $signed(in_a[0]) * $signed(in_side.v[1]);
      pb[5] <= $signed(in_a[1]) * $signed(in_side.v[0]);
      for (int i = 0; i < 3; i++) begin
        pa[i] <= $signed(in_a[i]) * $signed(in_side.eye[i]);
        pv[i] <= $signed(in_side.v[i]) * $signed(in_side.eye[i]);
      end

      c2 <= c1;
      braw[0] <= 39'(pb[0]) - 39'(pb[1]);
      braw[1] <= 39'(pb[2]) - 39'(pb[3]);
      braw[2] <= 39'(pb[4]) - 39'(pb[5]);
      da <= 53'(pa[0]) + 53'(pa[1]) + 53'(pa[2]);
      dv <= 53'(pv[0]) + 53'(pv[1]) + 53'(pv[2]);

      c3 <= c2;
      for (int i = 0; i < 3; i++) b3[i] <= 24'(vmb_pkg::round16(64'(braw[i])));
      ta3 <= vmb_pkg::sat32(-vmb_pkg::round16(64'(da)));
      tv3 <= vmb_pkg::sat32(vmb_pkg::round16(64'(dv)));

      c4 <= c3;
      ta4 <= ta3;
      tv4 <= tv3;
      for (int i = 0; i < 3; i++) begin
        b4[i] <= b3[i];
        pbe[i] <= $signed(b3[i]) * $signed(c3.eye[i]);
      end

      out_mat.vld <= c4.vld;
      out_mat.ok <= c4.ok;
      for (int i = 0; i < 3; i++) begin
        out_mat.m[0][i] <= c4.ok ? 32'(c4.a[i]) : '0;
        out_mat.m[1][i] <= c4.ok ? 32'(b4[i]) : '0;
        out_mat.m[2][i] <= c4.ok ? 32'(-c4.v[i]) : '0;
      end
      out_mat.m[0][3] <= c4.ok ? ta4 : '0;
      out_mat.m[1][3] <= c4.ok ? tb : '0;
      out_mat.m[2][3] <= c4.ok ? tv4 : '0;
    end
  end

endmodule

// ===== rtl/core/view_matrix_builder.sv =====
// top level of the look-at view matrix builder: input capture, row output
// depends on vmb_pkg, vmb_unitize, vmb_cross and vmb_rows
//
// usage: drive eye, center and up (signed Q16.16) and raise start; a
// transaction is taken at a rising edge with start high and busy low.
// busy stays high after each accepted transaction until the gap counter runs
// out, so a new transaction can enter the pipeline before the last has left it;
// the gap spaces matrices at the output port, which emits one matrix row per cycle.
// the four rows leave on result_valid in consecutive cycles, row_index 0 to 3,
// last_row marking row 3; row 0 is shown from the hold register once vmb_rows delivers the matrix.
// degenerate flags a zero-length forward or side vector; rows 0 to 2 are
// then zero and row 3 is still 0 0 0 1.0.
// results cannot be held off: each row is valid for exactly one cycle.
// synchronous reset clears all valid bits and busy; nothing else is needed.
module view_matrix_builder (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  output logic result_valid,
  output logic [1:0] row_index,
  output logic signed [31:0] col_0,
  output logic signed [31:0] col_1,
  output logic signed [31:0] col_2,
  output logic signed [31:0] col_3,
  output logic degenerate,
  output logic last_row
);

  localparam int GW = $clog2(vmb_pkg::ITEM_CYC);

  logic [GW-1:0] gap;
  logic accept;
  logic s0_vld, s1_vld;
  vmb_pkg::q16_t [2:0] s0_eye, s0_ctr, s0_up;
  vmb_pkg::vec_el_t [2:0] s1_d;
  vmb_pkg::side_t s1_side;

  logic u1_vld, x_vld, u2_vld;
  vmb_pkg::unit_t [2:0] u1_u, u2_a;
  vmb_pkg::side_t u1_side, x_in_side, x_side, u2_side;
  vmb_pkg::vec_el_t [2:0] x_c;
  vmb_pkg::mat_t mat;

  vmb_pkg::mat_t hold;
  logic [1:0] ocnt;
  logic oact;

  assign accept = start & ~busy;
  assign busy = (gap != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
    end else begin
      if (accept) gap <= GW'(vmb_pkg::ITEM_CYC - 1);
      else if (gap != '0) gap <= gap - 1'b1;
      s0_vld <= accept;
      if (accept) begin
        s0_eye <= {eye_z, eye_y, eye_x};
        s0_ctr <= {center_z, center_y, center_x};
        s0_up <= {up_z, up_y, up_x};
      end
      s1_vld <= s0_vld;
      for (int i = 0; i < 3; i++) begin
        s1_d[i] <= vmb_pkg::VW'(s0_ctr[i]) - vmb_pkg::VW'(s0_eye[i]);
      end
      s1_side.eye <= s0_eye;
      s1_side.up <= s0_up;
      s1_side.v <= '0;
      s1_side.ok <= 1'b1;
    end
  end

  vmb_unitize u_fwd (
    .clk(clk), .rst(rst),
    .in_vld(s1_vld), .in_v(s1_d), .in_side(s1_side),
    .out_vld(u1_vld), .out_u(u1_u), .out_side(u1_side)
  );

  always_comb begin
    x_in_side = u1_side;
    x_in_side.v = u1_u;
  end

  vmb_cross u_cross (
    .clk(clk), .rst(rst),
    .in_vld(u1_vld), .in_side(x_in_side),
    .out_vld(x_vld), .out_c(x_c), .out_side(x_side)
  );

  vmb_unitize u_side (
    .clk(clk), .rst(rst),
    .in_vld(x_vld), .in_v(x_c), .in_side(x_side),
    .out_vld(u2_vld), .out_u(u2_a), .out_side(u2_side)
  );

  vmb_rows u_rows (
    .clk(clk), .rst(rst),
    .in_vld(u2_vld), .in_a(u2_a), .in_side(u2_side),
    .out_mat(mat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      oact <= 1'b0;
      ocnt <= '0;
    end else if (mat.vld) begin
      hold <= mat;
      oact <= 1'b1;
      ocnt <= '0;
    end else if (oact) begin
      ocnt <= ocnt + 1'b1;
      if (ocnt == vmb_pkg::LAST_ROW) oact <= 1'b0;
    end
  end

  always_comb begin
    case (ocnt)
      2'd0: {col_0, col_1, col_2, col_3} =
              {hold.m[0][0], hold.m[0][1], hold.m[0][2], hold.m[0][3]};
      2'd1: {col_0, col_1, col_2, col_3} =
              {hold.m[1][0], hold.m[1][1], hold.m[1][2], hold.m[1][3]};
      2'd2: {col_0, col_1, col_2, col_3} =
              {hold.m[2][0], hold.m[2][1], hold.m[2][2], hold.m[2][3]};
      default: {col_0, col_1, col_2, col_3} = {32'sd0, 32'sd0, 32'sd0, vmb_pkg::ONE_Q16};
    endcase
  end

  assign result_valid = oact;
  assign row_index = ocnt;
  assign degenerate = ~hold.ok;
  assign last_row = (ocnt == vmb_pkg::LAST_ROW);

endmodule
